/* sv/multi_voice_chorus_top_macros.svh */
// Assertion macros shared by the chorus checker.
`ifndef MULTI_VOICE_CHORUS_TOP_MACROS_SVH
`define MULTI_VOICE_CHORUS_TOP_MACROS_SVH

// Property checked only out of reset.
`define MVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define MVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/mvc_pkg.sv */
// Shared types, constants and tables of the multi-voice chorus.
package mvc_pkg;

  localparam int SAMP_W     = 16;
  localparam int DLY_W      = 20;
  localparam int DEPTH_W    = 16;
  localparam int STEP_W     = 23;
  localparam int PH_W       = 24;
  localparam int VOICE_W    = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;
  localparam int LFO_W      = 17;   // 0..65536
  localparam int PH_ONE     = 1 << 24;

  localparam int DELAY_LEN_DEF  = 8192;
  localparam int MAX_VOICES_DEF = 8;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE, REG_SWEEP, REG_DEPTH, REG_STEP, REG_SHAPE, REG_INTERP, REG_VOICES
  } reg_idx_t;

  typedef enum logic [1:0] {
    SHP_SINE, SHP_TRI, SHP_SQUARE, SHP_SLOPED
  } shape_t;

  // Interpolation codes; code 3 falls back to nearest
  localparam logic [1:0] INT_NEAR  = 2'd0;
  localparam logic [1:0] INT_LIN   = 2'd1;
  localparam logic [1:0] INT_CUBIC = 2'd2;

  localparam logic [DLY_W-1:0]   RST_BASE   = 20'd338688;
  localparam logic [DLY_W-1:0]   RST_SWEEP  = 20'd225792;
  localparam logic [DEPTH_W-1:0] RST_DEPTH  = 16'd32768;
  localparam logic [STEP_W-1:0]  RST_STEP   = 23'd76;
  localparam logic [1:0]         RST_INTERP = INT_LIN;
  localparam logic [VOICE_W-1:0] RST_VOICES = 4'd2;

  // Sloped-square edge thresholds
  localparam logic [PH_W-1:0] SLOPE_T1 = 24'd8053064;
  localparam logic [PH_W-1:0] SLOPE_T3 = 24'd16441672;

  typedef struct packed {
    logic [DLY_W-1:0]   base_delay;
    logic [DLY_W-1:0]   sweep_width;
    logic [DEPTH_W-1:0] mix_depth;
    logic [STEP_W-1:0]  phase_step;
    shape_t             lfo_shape;
    logic [1:0]         interp_mode;
    logic [VOICE_W-1:0] voice_count;
  } cfg_t;

  typedef struct packed {
    logic signed [SAMP_W-1:0] sample;
    logic [VOICE_W-1:0]       taps;
  } item_t;

  // Front to back hand-over
  typedef struct packed {
    logic  valid;
    item_t item;
  } fb_t;

  // Per-tap phase offset step: quotient of 2^24 / n
  function automatic logic [PH_W-1:0] off_quot(input logic [VOICE_W-1:0] n);
    logic [PH_W-1:0] q;
    case (n)
      4'd2:    q = 24'(PH_ONE / 2);
      4'd3:    q = 24'(PH_ONE / 3);
      4'd4:    q = 24'(PH_ONE / 4);
      4'd5:    q = 24'(PH_ONE / 5);
      4'd6:    q = 24'(PH_ONE / 6);
      4'd7:    q = 24'(PH_ONE / 7);
      4'd8:    q = 24'(PH_ONE / 8);
      4'd9:    q = 24'(PH_ONE / 9);
      4'd10:   q = 24'(PH_ONE / 10);
      4'd11:   q = 24'(PH_ONE / 11);
      4'd12:   q = 24'(PH_ONE / 12);
      4'd13:   q = 24'(PH_ONE / 13);
      4'd14:   q = 24'(PH_ONE / 14);
      4'd15:   q = 24'(PH_ONE / 15);
      default: q = '0;
    endcase
    return q;
  endfunction

  // Remainder of 2^24 / n
  function automatic logic [VOICE_W-1:0] off_rem(input logic [VOICE_W-1:0] n);
    logic [VOICE_W-1:0] r;
    case (n)
      4'd3:    r = 4'(PH_ONE % 3);
      4'd5:    r = 4'(PH_ONE % 5);
      4'd6:    r = 4'(PH_ONE % 6);
      4'd7:    r = 4'(PH_ONE % 7);
      4'd9:    r = 4'(PH_ONE % 9);
      4'd10:   r = 4'(PH_ONE % 10);
      4'd11:   r = 4'(PH_ONE % 11);
      4'd12:   r = 4'(PH_ONE % 12);
      4'd13:   r = 4'(PH_ONE % 13);
      4'd14:   r = 4'(PH_ONE % 14);
      4'd15:   r = 4'(PH_ONE % 15);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* sv/mvc_ram.sv */
// Generic simple dual-port RAM with registered read.
module mvc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/mvc_front.sv */
// Input queue: takes sample beats and tags each with its tap count.
module mvc_front #(
  parameter int MAX_VOICES = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               push,
  output logic                               full,
  input  logic signed [mvc_pkg::SAMP_W-1:0]  sample_in,
  input  logic [mvc_pkg::VOICE_W-1:0]        voice_count,
  input  logic                               hold,
  input  logic                               deq,
  output mvc_pkg::fb_t                       fb
);
  import mvc_pkg::*;

  item_t              q_r [2];
  logic               wr_r, rd_r;
  logic [1:0]         cnt_r;
  logic               acc;
  logic [VOICE_W-1:0] taps;

  assign full = (cnt_r == 2'd2) || hold;
  assign acc  = push && !full;

  // Voice count clamp: zero means dry only, large values saturate
  always_comb begin
    if (voice_count == '0) begin
      taps = '0;
    end else if (int'(voice_count) > MAX_VOICES) begin
      taps = VOICE_W'(MAX_VOICES - 1);
    end else begin
      taps = voice_count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wr_r] <= '{sample: sample_in, taps: taps};
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (acc) wr_r <= !wr_r;
      if (deq) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(acc) - 2'(deq);
    end
  end

  assign fb.valid = (cnt_r != 2'd0);
  assign fb.item  = q_r[rd_r];

endmodule

/* sv/mvc_outq.sv */
// Two-entry result queue between the engine and the result port.
module mvc_outq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr,
  input  logic signed [mvc_pkg::SAMP_W-1:0] wdata,
  output logic                              full,
  input  logic                              pop,
  output logic                              empty,
  output logic signed [mvc_pkg::SAMP_W-1:0] rdata
);
  import mvc_pkg::*;

  logic signed [SAMP_W-1:0] q_r [2];
  logic                     wr_r, rd_r;
  logic [1:0]               cnt_r;
  logic                     rd;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rd    = pop && !empty;
  assign rdata = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wr_r <= !wr_r;
      if (rd) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

endmodule

/* sv/mvc_back.sv */
// Tap engine: LFO, delay, store reads, interp, mix; a step a cycle bar stalls.
module mvc_back #(
  parameter int DELAY_LEN  = 8192,
  parameter int MAX_VOICES = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mvc_pkg::cfg_t                     cfg,
  input  mvc_pkg::fb_t                      fb,
  output logic                              deq,
  output logic                              clearing,
  output logic                              res_wr,
  output logic signed [mvc_pkg::SAMP_W-1:0] res_data,
  input  logic                              res_full
);
  import mvc_pkg::*;

  localparam int AW        = $clog2(DELAY_LEN);
  localparam int PW        = AW + 8;
  localparam int SPAN      = DELAY_LEN * 256;
  localparam int DW        = 22;
  localparam int MOD_STEPS = (PW < DW) ? DW - PW : 1;
  localparam int KW        = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;
  localparam int TVW       = $clog2(MAX_VOICES) + 1;
  localparam int ACC_W     = 56;
  localparam int TAP_W     = 36;
  localparam int CUB_W     = 48;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_PH, S_SX2, S_ST1, S_ST2, S_ST3, S_SS, S_DLY, S_MOD,
    S_POS, S_IDX, S_RD, S_RDW, S_INT, S_CB2, S_CB3, S_CB4, S_MIX, S_FIN
  } state_t;

  state_t                      state_r;
  logic [AW-1:0]               clr_r, wp_r;
  logic [PH_W-1:0]             phase_r, off_r;
  logic [VOICE_W-1:0]          rem_r, ntap_r;
  logic [TVW-1:0]              tap_cnt_r;
  logic signed [SAMP_W-1:0]    x_in_r;
  logic [LFO_W-1:0]            x_r, x2_r, t_r, lfo_r;
  logic                        neg_r;
  logic [DW-1:0]               d_r;
  logic [KW-1:0]               k_r;
  logic [PW-1:0]               pos_r;
  logic [7:0]                  f_r;
  logic [AW-1:0]               addr_r [4];
  logic [1:0]                  rd_k_r, rd_last_r;
  logic signed [SAMP_W-1:0]    smp_r [4];
  logic signed [18:0]          ca_r;
  logic signed [19:0]          cb_r;
  logic signed [17:0]          cc_r;
  logic [15:0]                 f2_r;
  logic [23:0]                 f3_r;
  logic signed [CUB_W-1:0]     ta_r, tb_r, tc_r;
  logic signed [TAP_W-1:0]     tap_r;
  logic signed [ACC_W-1:0]     acc_r;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [SAMP_W-1:0]           ram_wdata, ram_rdata;

  // Combinational helpers
  logic [PH_W-1:0]             p;
  logic [22:0]                 rm;
  logic [31:0]                 slope_a, slope_b;
  logic [LFO_W-1:0]            lfo_simple;
  logic [33:0]                 s_prod;
  logic [LFO_W:0]              s_val;
  logic [36:0]                 sw_prod;
  logic [CUB_W-1:0]            span_sh;
  logic [PW:0]                 pos_sum;
  logic [AW-1:0]               i_idx;
  logic [AW:0]                 i2, n_idx;
  logic [PW:0]                 n_sum;
  logic signed [CUB_W-1:0]     cub_sum;
  logic signed [ACC_W-1:0]     rnd;
  logic signed [24:0]          y;
  logic signed [SAMP_W-1:0]    y_sat;
  logic [VOICE_W:0]            rem_sum;

  assign clearing = (state_r == S_CLR);
  assign p        = phase_r + off_r;

  // Simple LFO shapes and the sine quarter-wave argument
  always_comb begin
    rm      = p[22] ? 23'(23'h400000 - 23'(p[21:0])) : 23'(p[21:0]);
    slope_a = (32'(p - SLOPE_T1) * 32'd50) >> 8;
    slope_b = (32'(p - SLOPE_T3) * 32'd50) >> 8;
    case (cfg.lfo_shape)
      SHP_TRI: begin
        if (p < 24'h400000)      lfo_simple = 17'(17'd32768 + 17'(p >> 7));
        else if (p < 24'hC00000) lfo_simple = 17'(17'd65536 - 17'((p - 24'h400000) >> 7));
        else                     lfo_simple = 17'((p - 24'hC00000) >> 7);
      end
      SHP_SQUARE: lfo_simple = (p < 24'h800000) ? 17'd65536 : 17'd0;
      SHP_SLOPED: begin
        if (p < SLOPE_T1)        lfo_simple = 17'd65536;
        else if (p < 24'h800000) lfo_simple = 17'(32'd65536 - ((slope_a > 32'd65536) ?
                                                               32'd65536 : slope_a));
        else if (p < SLOPE_T3)   lfo_simple = 17'd0;
        else                     lfo_simple = (slope_b > 32'd65536) ? 17'd65536 :
                                                                      17'(slope_b);
      end
      default: lfo_simple = '0;
    endcase
  end

  // Sine closing product, clamped
  always_comb begin
    s_prod = 34'(t_r) * 34'(x_r);
    s_val  = (s_prod[33:16] > 18'd65536) ? 18'd65536 : s_prod[33:16];
  end

  // Delay, modulo and read-position arithmetic
  always_comb begin
    sw_prod = 37'(cfg.sweep_width) * 37'(lfo_r);
    span_sh = CUB_W'(SPAN) << k_r;
    pos_sum = (PW+1)'({wp_r, 8'd0}) + (PW+1)'(SPAN) - (PW+1)'(d_r);
    if (pos_sum >= (PW+1)'(SPAN)) pos_sum = pos_sum - (PW+1)'(SPAN);
    i_idx   = pos_r[PW-1:8];
    i2      = (AW+1)'(i_idx) + (AW+1)'(2);
    n_sum   = (PW+1)'(pos_r) + (PW+1)'(128);
    n_idx   = n_sum[PW:8];
  end

  // Cubic sum, final rounding and saturation
  always_comb begin
    cub_sum = ta_r + tb_r + tc_r + (CUB_W'(smp_r[1]) <<< 25);
    rnd     = acc_r + (ACC_W'(1) <<< 30);
    y       = 25'(rnd >>> 31);
    if (y > 25'sd32767)       y_sat = 16'sd32767;
    else if (y < -25'sd32768) y_sat = -16'sd32768;
    else                      y_sat = 16'(y);
    rem_sum = (VOICE_W+1)'(rem_r) + (VOICE_W+1)'(off_rem(ntap_r));
  end

  // Store port, dequeue and result-write control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = 16'(x_in_r);
    ram_raddr = addr_r[rd_k_r];
    deq       = 1'b0;
    res_wr    = 1'b0;
    res_data  = y_sat;
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      S_IDLE: deq = fb.valid;
      S_FIN: begin
        ram_we = !res_full;
        res_wr = !res_full;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      wp_r    <= '0;
      phase_r <= '0;
    end else begin
      unique case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(DELAY_LEN - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (fb.valid) begin
            x_in_r    <= fb.item.sample;
            ntap_r    <= fb.item.taps;
            acc_r     <= ACC_W'(fb.item.sample) <<< 31;
            off_r     <= '0;
            rem_r     <= '0;
            tap_cnt_r <= '0;
            state_r   <= (fb.item.taps == '0) ? S_FIN : S_PH;
          end
        end
        S_PH: begin
          x_r   <= 17'(rm >> 6);
          neg_r <= p[23];
          lfo_r <= lfo_simple;
          state_r <= (cfg.lfo_shape == SHP_SINE) ? S_SX2 : S_DLY;
        end
        S_SX2: begin
          x2_r    <= 17'((34'(x_r) * 34'(x_r)) >> 16);
          state_r <= S_ST1;
        end
        S_ST1: begin
          t_r     <= 17'(17'd5223 - 17'((34'(x2_r) * 34'd307) >> 16));
          state_r <= S_ST2;
        end
        S_ST2: begin
          t_r     <= 17'(17'd42334 - 17'((34'(t_r) * 34'(x2_r)) >> 16));
          state_r <= S_ST3;
        end
        S_ST3: begin
          t_r     <= 17'(17'd102944 - 17'((34'(t_r) * 34'(x2_r)) >> 16));
          state_r <= S_SS;
        end
        S_SS: begin
          lfo_r   <= neg_r ? 17'(17'd32768 - 17'(s_val >> 1)) :
                             17'(17'd32768 + 17'(s_val >> 1));
          state_r <= S_DLY;
        end
        S_DLY: begin
          d_r     <= DW'(cfg.base_delay) + DW'(sw_prod >> 16);
          k_r     <= KW'(MOD_STEPS - 1);
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (CUB_W'(d_r) >= span_sh) d_r <= DW'(CUB_W'(d_r) - span_sh);
          if (k_r == '0) state_r <= S_POS;
          else           k_r <= k_r - 1'b1;
        end
        S_POS: begin
          pos_r   <= PW'(pos_sum);
          state_r <= S_IDX;
        end
        S_IDX: begin
          f_r       <= pos_r[7:0];
          addr_r[0] <= (i_idx == '0) ? AW'(DELAY_LEN - 1) : i_idx - 1'b1;
          addr_r[2] <= (i_idx == AW'(DELAY_LEN - 1)) ? '0 : i_idx + 1'b1;
          addr_r[3] <= (i2 >= (AW+1)'(DELAY_LEN)) ? AW'(i2 - (AW+1)'(DELAY_LEN)) :
                                                    AW'(i2);
          case (cfg.interp_mode)
            INT_LIN: begin
              addr_r[1] <= i_idx;
              rd_k_r    <= 2'd1;
              rd_last_r <= 2'd2;
            end
            INT_CUBIC: begin
              addr_r[1] <= i_idx;
              rd_k_r    <= 2'd0;
              rd_last_r <= 2'd3;
            end
            default: begin
              addr_r[1] <= (n_idx >= (AW+1)'(DELAY_LEN)) ? '0 : AW'(n_idx);
              rd_k_r    <= 2'd1;
              rd_last_r <= 2'd1;
            end
          endcase
          state_r <= S_RD;
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          smp_r[rd_k_r] <= $signed(ram_rdata);
          if (rd_k_r == rd_last_r) begin
            state_r <= S_INT;
          end else begin
            rd_k_r  <= rd_k_r + 1'b1;
            state_r <= S_RD;
          end
        end
        S_INT: begin
          case (cfg.interp_mode)
            INT_LIN: begin
              tap_r <= (TAP_W'(smp_r[1]) * TAP_W'($signed({1'b0, 9'(9'd256 - 9'(f_r))}))
                      + TAP_W'(smp_r[2]) * TAP_W'($signed({1'b0, f_r}))) <<< 8;
              state_r <= S_MIX;
            end
            INT_CUBIC: begin
              ca_r <= 19'(-19'(smp_r[0]) + 19'sd3 * 19'(smp_r[1])
                          - 19'sd3 * 19'(smp_r[2]) + 19'(smp_r[3]));
              cb_r <= 20'(20'sd2 * 20'(smp_r[0]) - 20'sd5 * 20'(smp_r[1])
                          + 20'sd4 * 20'(smp_r[2]) - 20'(smp_r[3]));
              cc_r <= 18'(18'(smp_r[2]) - 18'(smp_r[0]));
              f2_r <= 16'(f_r) * 16'(f_r);
              state_r <= S_CB2;
            end
            default: begin
              tap_r   <= TAP_W'(smp_r[1]) <<< 16;
              state_r <= S_MIX;
            end
          endcase
        end
        S_CB2: begin
          f3_r    <= 24'(f2_r) * 24'(f_r);
          tb_r    <= (CUB_W'(cb_r) * CUB_W'($signed({1'b0, f2_r}))) <<< 8;
          state_r <= S_CB3;
        end
        S_CB3: begin
          ta_r    <= CUB_W'(ca_r) * CUB_W'($signed({1'b0, f3_r}));
          tc_r    <= (CUB_W'(cc_r) * CUB_W'($signed({1'b0, f_r}))) <<< 16;
          state_r <= S_CB4;
        end
        S_CB4: begin
          tap_r   <= TAP_W'(cub_sum >>> 9);
          state_r <= S_MIX;
        end
        S_MIX: begin
          acc_r <= acc_r + ACC_W'(ACC_W'($signed({1'b0, cfg.mix_depth})) * ACC_W'(tap_r));
          // Next tap offset: running quotient and remainder of j * 2^24 / taps
          if (rem_sum >= (VOICE_W+1)'(ntap_r)) begin
            rem_r <= VOICE_W'(rem_sum - (VOICE_W+1)'(ntap_r));
            off_r <= off_r + off_quot(ntap_r) + 1'b1;
          end else begin
            rem_r <= VOICE_W'(rem_sum);
            off_r <= off_r + off_quot(ntap_r);
          end
          tap_cnt_r <= tap_cnt_r + 1'b1;
          state_r   <= (TVW'(tap_cnt_r + 1'b1) == TVW'(ntap_r)) ? S_FIN : S_PH;
        end
        S_FIN: begin
          if (!res_full) begin
            wp_r    <= (wp_r == AW'(DELAY_LEN - 1)) ? '0 : wp_r + 1'b1;
            phase_r <= phase_r + PH_W'(cfg.phase_step);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  mvc_ram #(
    .WIDTH (SAMP_W),
    .DEPTH (DELAY_LEN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* sv/multi_voice_chorus_top.sv */
// Multi-voice chorus top level: config registers, input queue, tap engine, result queue.
//
//  channel   ports                                   beat taken when
//  input     push, full, in_sample_in                push && !full
//  result    empty, pop, out_sample_out              pop && !empty
//  config    cfg_we, cfg_index, cfg_data             cfg_we
//
// Each tap runs S_PH, S_DLY, S_MOD, S_POS, S_IDX, the store reads, S_INT and S_MIX: a
// sine LFO adds S_SX2, S_ST1 to S_ST3 and S_SS, the delay wrap takes one quotient bit
// per cycle (one at the default store length), every store read takes S_RD and S_RDW on
// the single read port and cubic interpolation adds S_CB2 to S_CB4. A sample with no
// taps goes from S_IDLE to S_FIN. The store is cleared after reset with full held high.
// Two queue entries on each side let input and result beats flow while the engine works.
module multi_voice_chorus_top #(
  parameter int DELAY_LEN  = mvc_pkg::DELAY_LEN_DEF,
  parameter int MAX_VOICES = mvc_pkg::MAX_VOICES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [mvc_pkg::SAMP_W-1:0]     in_sample_in,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [mvc_pkg::SAMP_W-1:0]     out_sample_out,
  input  logic                                  cfg_we,
  input  logic [mvc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [mvc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import mvc_pkg::*;

  cfg_t                     cfg_r;
  fb_t                      fb;
  logic                     deq, clearing, res_wr, res_full;
  logic signed [SAMP_W-1:0] res_data;

  // Config registers, masked to width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_delay  <= RST_BASE;
      cfg_r.sweep_width <= RST_SWEEP;
      cfg_r.mix_depth   <= RST_DEPTH;
      cfg_r.phase_step  <= RST_STEP;
      cfg_r.lfo_shape   <= SHP_SINE;
      cfg_r.interp_mode <= RST_INTERP;
      cfg_r.voice_count <= RST_VOICES;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_BASE:   cfg_r.base_delay  <= cfg_data[DLY_W-1:0];
        REG_SWEEP:  cfg_r.sweep_width <= cfg_data[DLY_W-1:0];
        REG_DEPTH:  cfg_r.mix_depth   <= cfg_data[DEPTH_W-1:0];
        REG_STEP:   cfg_r.phase_step  <= cfg_data[STEP_W-1:0];
        REG_SHAPE:  cfg_r.lfo_shape   <= shape_t'(cfg_data[1:0]);
        REG_INTERP: cfg_r.interp_mode <= cfg_data[1:0];
        REG_VOICES: cfg_r.voice_count <= cfg_data[VOICE_W-1:0];
        default: ;
      endcase
    end
  end

  mvc_front #(
    .MAX_VOICES (MAX_VOICES)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .sample_in   (in_sample_in),
    .voice_count (cfg_r.voice_count),
    .hold        (clearing),
    .deq         (deq),
    .fb          (fb)
  );

  mvc_back #(
    .DELAY_LEN  (DELAY_LEN),
    .MAX_VOICES (MAX_VOICES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .fb       (fb),
    .deq      (deq),
    .clearing (clearing),
    .res_wr   (res_wr),
    .res_data (res_data),
    .res_full (res_full)
  );

  mvc_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (res_wr),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .empty (empty),
    .rdata (out_sample_out)
  );

endmodule

/* sv/mvc_checker.sv */
// Port-level checker for the chorus top level, with its bind.
`include "multi_voice_chorus_top_macros.svh"

module mvc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              full,
  input logic                              empty,
  input logic                              pop,
  input logic signed [mvc_pkg::SAMP_W-1:0] out_sample_out
);

  // Reset leaves no result and blocks input for the clearing pass
  `MVC_ASSERT_ALWAYS(a_rst_state, !rst_n |=> (full && empty), "reset must block input, empty results")

  // A waiting result holds until popped
  `MVC_ASSERT(a_res_hold, (rst_n && !empty && !pop) |=> (!empty && $stable(out_sample_out)), "result changed while waiting")

  // Results leave only by a pop
  `MVC_ASSERT(a_res_drop, ($rose(empty) && $past(rst_n)) |-> $past(pop), "result lost without a pop")

  // No result straight out of reset
  `MVC_ASSERT(a_res_early, $fell(empty) |-> ($past(rst_n) && $past(rst_n, 2)), "result right after reset")

endmodule

bind multi_voice_chorus_top mvc_checker u_mvc_checker (.*);
